// ===== sv/npl_pkg.sv =====
// Shared types and constants for the nearest point lookup block.
// Used by every module of the block except npl_ram; depends on nothing.
package npl_pkg;

  // Table size default; top level hands it down as MAX_POINTS
  localparam int DEF_MAX_POINTS = 1024;

  // Field widths fixed by the interface
  localparam int COORD_W    = 32;
  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 11;
  localparam int CUTOFF_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int SQ_W       = 2 * COORD_W;   // squared distance term, Q32.32
  localparam int SUM_W      = SQ_W + 2;      // sum of three terms, no overflow

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'd5000;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_POINT_COUNT = 1'b0,
    REG_CUTOFF      = 1'b1
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_RESULT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_write;   // write one table entry
    logic start_query;  // latch query point, reset bound and scan counter
    logic scan_issue;   // read next entry into the distance pipeline
    logic fetch_value;  // read value vector of the selected entry
    logic load_out;     // move result into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;   // nothing to search
    logic scan_last;    // scan counter at the last entry
    logic pipe_busy;    // distance pipeline still holds entries
    logic out_free;     // output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== sv/npl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the point table and the value table.
module npl_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/npl_ctrl.sv =====
// Controller for the nearest point lookup: sequences load, scan, drain,
// value fetch and result handoff. Depends on npl_pkg.
module npl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                mode,
  output logic                in_ready,
  input  npl_pkg::dp_status_t stat,
  output npl_pkg::ctrl_cmd_t  cmd
);

  npl_pkg::state_t state, state_next;
  logic            in_xfer;

  assign in_ready = (state == npl_pkg::ST_IDLE) && !rst;
  assign in_xfer  = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      npl_pkg::ST_IDLE: begin
        if (in_xfer && (mode == npl_pkg::MODE_QUERY)) begin
          state_next = stat.count_zero ? npl_pkg::ST_FETCH : npl_pkg::ST_SCAN;
        end
      end
      npl_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = npl_pkg::ST_DRAIN;
        end
      end
      npl_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = npl_pkg::ST_FETCH;
        end
      end
      npl_pkg::ST_FETCH: begin
        state_next = npl_pkg::ST_RESULT;
      end
      npl_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          state_next = npl_pkg::ST_IDLE;
        end
      end
      default: state_next = npl_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      npl_pkg::ST_IDLE: begin
        cmd.load_write  = in_xfer && (mode == npl_pkg::MODE_LOAD);
        cmd.start_query = in_xfer && (mode == npl_pkg::MODE_QUERY);
      end
      npl_pkg::ST_SCAN:   cmd.scan_issue  = 1'b1;
      npl_pkg::ST_DRAIN:  cmd = '0;
      npl_pkg::ST_FETCH:  cmd.fetch_value = 1'b1;
      npl_pkg::ST_RESULT: cmd.load_out    = stat.out_free;
      default:            cmd = '0;
    endcase
  end

endmodule

// ===== sv/npl_datapath.sv =====
// Datapath for the nearest point lookup: config registers, point and value
// tables, distance pipeline, running minimum and output register.
// Depends on npl_pkg and npl_ram.
module npl_datapath #(
  parameter int MAX_POINTS = npl_pkg::DEF_MAX_POINTS,
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  npl_pkg::ctrl_cmd_t                     cmd,
  output npl_pkg::dp_status_t                    stat,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [npl_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input payload
  input  logic [npl_pkg::IDX_W-1:0]              entry_index,
  input  logic signed [npl_pkg::COORD_W-1:0]     coord_x,
  input  logic signed [npl_pkg::COORD_W-1:0]     coord_y,
  input  logic signed [npl_pkg::COORD_W-1:0]     coord_z,
  input  logic signed [npl_pkg::COORD_W-1:0]     load_value_x,
  input  logic signed [npl_pkg::COORD_W-1:0]     load_value_y,
  input  logic signed [npl_pkg::COORD_W-1:0]     load_value_z,
  // output
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [npl_pkg::IDX_W-1:0]              match_index,
  output logic                                   any_within,
  output logic signed [npl_pkg::COORD_W-1:0]     result_x,
  output logic signed [npl_pkg::COORD_W-1:0]     result_y,
  output logic signed [npl_pkg::COORD_W-1:0]     result_z
);

  localparam int CW  = npl_pkg::COORD_W;
  localparam int TW  = 3 * CW;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = CW + 1;

  // Configuration registers
  logic [npl_pkg::COUNT_W-1:0]  point_count;
  logic [npl_pkg::CUTOFF_W-1:0] cutoff_distance;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count     <= '0;
      cutoff_distance <= npl_pkg::CUTOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (npl_pkg::cfg_reg_t'(cfg_index))
        npl_pkg::REG_POINT_COUNT: point_count <= cfg_data[npl_pkg::COUNT_W-1:0];
        npl_pkg::REG_CUTOFF:      cutoff_distance <= cfg_data[npl_pkg::CUTOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Searched entry count, saturated to the table size
  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_minus1;
  logic [AW-1:0] last_addr;

  always_comb begin
    if (32'(point_count) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
    n_minus1  = n_eff - NW'(1);
    last_addr = n_minus1[AW-1:0];
  end

  // Tables: point triple and value triple, written together by a load
  logic          tbl_wr;
  logic [AW-1:0] tbl_wr_addr;
  logic [AW-1:0] scan_cnt;
  logic [AW-1:0] sel;
  logic [TW-1:0] pt_rd;
  logic [TW-1:0] val_rd;

  assign tbl_wr      = cmd.load_write && (32'(entry_index) < MAX_POINTS);
  assign tbl_wr_addr = AW'(entry_index);

  npl_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS), .ADDR_W(AW)) u_point_ram (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_wr_addr),
    .wr_data ({coord_z, coord_y, coord_x}),
    .rd_en   (cmd.scan_issue),
    .rd_addr (scan_cnt),
    .rd_data (pt_rd)
  );

  npl_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS), .ADDR_W(AW)) u_value_ram (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_wr_addr),
    .wr_data ({load_value_z, load_value_y, load_value_x}),
    .rd_en   (cmd.fetch_value),
    .rd_addr (sel),
    .rd_data (val_rd)
  );

  // Query point
  logic [CW-1:0] qx, qy, qz;

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      qx <= coord_x;
      qy <= coord_y;
      qz <= coord_z;
    end
  end

  // Scan counter
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      scan_cnt <= '0;
    end else if (cmd.scan_issue) begin
      scan_cnt <= scan_cnt + AW'(1);
    end
  end

  // Distance pipeline: table read, difference, square, sum, compare
  logic                   v1, v2, v3, v4;
  logic [AW-1:0]          idx1, idx2, idx3, idx4;
  logic signed [DW-1:0]   dx, dy, dz;
  logic signed [2*DW-1:0] px, py, pz;
  logic [npl_pkg::SQ_W-1:0]  sqx, sqy, sqz;
  logic [npl_pkg::SUM_W-1:0] dist2;
  logic [npl_pkg::SQ_W-1:0]  bound;
  logic                   found;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Difference stage
  always_ff @(posedge clk) begin
    idx1 <= scan_cnt;
    idx2 <= idx1;
    dx   <= $signed({qx[CW-1], qx}) - $signed({pt_rd[CW-1], pt_rd[CW-1:0]});
    dy   <= $signed({qy[CW-1], qy}) - $signed({pt_rd[2*CW-1], pt_rd[2*CW-1:CW]});
    dz   <= $signed({qz[CW-1], qz}) - $signed({pt_rd[3*CW-1], pt_rd[3*CW-1:2*CW]});
  end

  // Square stage; |d| < 2^32 so the square fits in 64 bits
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    idx3 <= idx2;
    sqx  <= px[npl_pkg::SQ_W-1:0];
    sqy  <= py[npl_pkg::SQ_W-1:0];
    sqz  <= pz[npl_pkg::SQ_W-1:0];
  end

  // Sum stage
  always_ff @(posedge clk) begin
    idx4  <= idx3;
    dist2 <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
  end

  // Running minimum; bound starts at cutoff squared in Q32.32
  logic [2*npl_pkg::CUTOFF_W-1:0] cut_sq;

  assign cut_sq = cutoff_distance * cutoff_distance;

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      bound <= {cut_sq, 32'd0};
      sel   <= '0;
      found <= 1'b0;
    end else if (v4 && (dist2 < {2'b00, bound})) begin
      bound <= dist2[npl_pkg::SQ_W-1:0];
      sel   <= idx4;
      found <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      match_index <= npl_pkg::IDX_W'(sel);
      any_within  <= found;
      result_x    <= val_rd[CW-1:0];
      result_y    <= val_rd[2*CW-1:CW];
      result_z    <= val_rd[3*CW-1:2*CW];
    end
  end

  // Status to the controller
  assign stat.count_zero = (n_eff == '0);
  assign stat.scan_last  = (scan_cnt == last_addr);
  assign stat.pipe_busy  = v1 || v2 || v3 || v4;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== sv/nearest_point_lookup.sv =====
// Top level of the nearest point lookup: controller plus datapath.
// Depends on npl_pkg, npl_ctrl, npl_datapath (and npl_ram below it).
//
// Usage:
//   Input channel (in_valid/in_ready) carries loads (mode 0) and queries
//   (mode 1). A load writes one table entry in the cycle it transfers and
//   produces no result; entries at or above MAX_POINTS are dropped.
//   A query scans entries 0 .. point_count-1 (saturated to MAX_POINTS) one
//   per cycle through a four-stage distance pipeline fed by the point RAM
//   read port, then reads the selected value vector from the value RAM.
//   Output channel (out_valid/out_ready) returns one result per query.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   point_count (index 0) and cutoff_distance (index 1); the user must write
//   them only while idle, as the block itself does not enforce it.
// Concurrency:
//   One query is in flight at a time; in_ready drops from query transfer
//   until its result is registered.
// Reset and stall:
//   Synchronous reset initialises control state and the config registers; table
//   contents are undefined until loaded. If the receiver stalls, the result
//   holds in the output register; loads are still taken meanwhile, and the
//   next query waits at its end until the output register frees up.
module nearest_point_lookup #(
  parameter int MAX_POINTS = npl_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [npl_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [npl_pkg::IDX_W-1:0]           entry_index,
  input  logic signed [npl_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [npl_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [npl_pkg::COORD_W-1:0]  coord_z,
  input  logic signed [npl_pkg::COORD_W-1:0]  load_value_x,
  input  logic signed [npl_pkg::COORD_W-1:0]  load_value_y,
  input  logic signed [npl_pkg::COORD_W-1:0]  load_value_z,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [npl_pkg::IDX_W-1:0]           match_index,
  output logic                                any_within,
  output logic signed [npl_pkg::COORD_W-1:0]  result_x,
  output logic signed [npl_pkg::COORD_W-1:0]  result_y,
  output logic signed [npl_pkg::COORD_W-1:0]  result_z
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  npl_pkg::ctrl_cmd_t  cmd;
  npl_pkg::dp_status_t stat;

  npl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npl_datapath #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entry_index  (entry_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .load_value_x (load_value_x),
    .load_value_y (load_value_y),
    .load_value_z (load_value_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_index  (match_index),
    .any_within   (any_within),
    .result_x     (result_x),
    .result_y     (result_y),
    .result_z     (result_z)
  );

endmodule

// ===== sv/npl_checker.sv =====
// Port-level checks for the nearest point lookup, bound to the top level.
// Depends on npl_pkg and nearest_point_lookup.
module npl_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               mode,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [npl_pkg::IDX_W-1:0]          match_index,
  input logic                               any_within,
  input logic signed [npl_pkg::COORD_W-1:0] result_x
);

  // Stalled result stays valid with match_index and result_x held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_index) && $stable(result_x))
    else $error("output dropped or changed while stalled");

  // A query transfer blocks the input until its result is done
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == npl_pkg::MODE_QUERY) |=> !in_ready)
    else $error("input accepted during a query");

  // A load never creates a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == npl_pkg::MODE_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after a load");

  // No match reports entry zero
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_within |-> (match_index == '0))
    else $error("nonzero index without a match");

endmodule

bind nearest_point_lookup npl_checker u_npl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .mode        (mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .match_index (match_index),
  .any_within  (any_within),
  .result_x    (result_x)
);
